// ----- design/controller_slot_event_bridge_top_macros.svh -----
`ifndef CONTROLLER_SLOT_EVENT_BRIDGE_TOP_MACROS_SVH
`define CONTROLLER_SLOT_EVENT_BRIDGE_TOP_MACROS_SVH

// same-cycle implication, reset gated
`define CSEB_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, reset gated
`define CSEB_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/cseb_pkg.sv -----
package cseb_pkg;

	localparam int unsigned SLOTS  = 16;
	localparam int unsigned SLOT_W = 4;
	localparam int unsigned BTN_W  = 21;
	localparam int unsigned SRC_W  = 22;
	localparam int unsigned ID_W   = 32;
	localparam int unsigned CNT_W  = 5;

	typedef enum logic [2:0] {
		EV_DISC     = 3'd0,
		EV_CONN     = 3'd1,
		EV_STATE    = 3'd2,
		EV_BAD_SLOT = 3'd3,
		EV_CAPACITY = 3'd4
	} event_kind_t;

	localparam logic       OP_ARRIVAL = 1'b0;
	localparam logic       OP_STATE   = 1'b1;

	localparam logic [1:0] REG_MAX_CTRL  = 2'd0;
	localparam logic [1:0] REG_BASIC_EN  = 2'd1;
	localparam logic [1:0] REG_RUMBLE_EN = 2'd2;

	// source bit feeding each remapped button
	localparam logic [4:0] BTN_SRC_BIT [BTN_W] = '{
		5'd12, 5'd13, 5'd14, 5'd15, 5'd0, 5'd1, 5'd2, 5'd3,
		5'd8, 5'd9, 5'd6, 5'd7, 5'd4, 5'd5, 5'd10, 5'd20,
		5'd16, 5'd17, 5'd18, 5'd19, 5'd21
	};

	typedef struct packed {
		logic                 id_we;
		logic                 id_re;
		logic                 cap_we;
		logic                 cap_re;
		logic [SLOT_W-1:0]    addr;
		logic [ID_W-1:0]      id_wdata;
		logic [BTN_W:0]       cap_wdata;
	} tbl_req_t;

	typedef struct packed {
		logic [ID_W-1:0]      id_rd;
		logic [BTN_W:0]       cap_rd;
	} tbl_rsp_t;

	typedef struct packed {
		event_kind_t          kind;
		logic [ID_W-1:0]      id;
		logic [BTN_W-1:0]     btn;
		logic                 rumble;
		logic signed [15:0]   lx;
		logic signed [15:0]   ly;
		logic signed [15:0]   rx;
		logic signed [15:0]   ry;
		logic [15:0]          lt;
		logic [15:0]          rt;
		logic                 last;
	} result_t;

	function automatic logic [BTN_W-1:0] remap_buttons(input logic [SRC_W-1:0] src);
		logic [BTN_W-1:0] r;
		for (int b = 0; b < BTN_W; b++) begin
			r[b] = src[BTN_SRC_BIT[b]];
		end
		return r;
	endfunction

	function automatic logic signed [15:0] neg_sat16(input logic signed [15:0] v);
		return (v == 16'sh8000) ? 16'sh7FFF : -v;
	endfunction

endpackage

// ----- design/controller_slot_event_bridge_top.sv -----
// Arrival transaction: no result unless the slot index is out of range; the block stays idle,
// so the next transaction can be taken while the output is free. An enabled state transaction
// gives one result per disconnected slot, then 0 to 2 more (connect and state, state, or a
// capacity error); output stalls hold it, and the next accept waits until it is idle again.
// Reset (arst_n low, asynchronous): control registers zero, all slots empty, next id one;
// slot memories are not cleared; valid bits mark their entries, so no clearing pass is needed.
module controller_slot_event_bridge_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [4:0]         cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               op,
	input  logic [3:0]         slot_index,
	input  logic [21:0]        supported_buttons,
	input  logic               rumble_capable,
	input  logic [15:0]        present_mask,
	input  logic [21:0]        pressed_buttons,
	input  logic signed [15:0] left_stick_x,
	input  logic signed [15:0] left_stick_y,
	input  logic signed [15:0] right_stick_x,
	input  logic signed [15:0] right_stick_y,
	input  logic [7:0]         left_trigger_in,
	input  logic [7:0]         right_trigger_in,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         event_kind,
	output logic [31:0]        assigned_id,
	output logic [20:0]        button_bits,
	output logic               rumble_supported,
	output logic signed [15:0] left_x_out,
	output logic signed [15:0] left_y_out,
	output logic signed [15:0] right_x_out,
	output logic signed [15:0] right_y_out,
	output logic [15:0]        left_trigger_out,
	output logic [15:0]        right_trigger_out,
	output logic               last
);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_SCAN  = 6'b000010,
		ST_DISC  = 6'b000100,
		ST_CONN  = 6'b001000,
		ST_STATE = 6'b010000,
		ST_ERR   = 6'b100000
	} state_t;

	state_t                             state_q;
	logic [cseb_pkg::CNT_W-1:0]         max_ctrl_q;
	logic                               basic_en_q;
	logic                               rumble_en_q;
	logic [cseb_pkg::SLOTS-1:0]         active_q;
	logic [cseb_pkg::SLOTS-1:0]         cap_vld_q;
	logic [cseb_pkg::SLOTS-1:0]         disc_q;
	logic [cseb_pkg::CNT_W-1:0]         cnt_q;
	logic [cseb_pkg::ID_W-1:0]          next_id_q;
	logic [cseb_pkg::ID_W-1:0]          cur_id_q;
	logic                               conn_q;
	logic                               disc_last_q;
	logic                               cap_vld_rd_q;

	logic [cseb_pkg::SLOT_W-1:0]        idx_q;
	logic [cseb_pkg::SLOTS-1:0]         mask_q;
	logic [cseb_pkg::BTN_W-1:0]         prs_q;
	logic signed [15:0]                 lx_q;
	logic signed [15:0]                 ly_q;
	logic signed [15:0]                 rx_q;
	logic signed [15:0]                 ry_q;
	logic [15:0]                        lt_q;
	logic [15:0]                        rt_q;

	cseb_pkg::result_t                  out_q;
	logic                               out_valid_q;

	cseb_pkg::tbl_req_t                 req;
	cseb_pkg::tbl_rsp_t                 rsp;
	cseb_pkg::result_t                  res_d;
	logic                               load;
	logic                               out_free;
	logic                               accept;
	logic                               bad_slot;
	logic                               state_on;
	logic [cseb_pkg::SLOT_W-1:0]        pick;
	logic [cseb_pkg::SLOTS-1:0]         disc_rest;
	logic                               scan_disc;
	logic                               scan_done;
	logic                               scan_have;
	logic                               cap_full;
	logic                               scan_err;
	logic                               scan_new;
	logic [cseb_pkg::BTN_W:0]           caps;

	cseb_slot_table u_table (
		.clk (clk),
		.req (req),
		.rsp (rsp)
	);

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = !((state_q == ST_IDLE) && out_free);
	assign accept   = in_valid && !in_stall;
	assign bad_slot = ({1'b0, slot_index} >= (cseb_pkg::SLOT_W + 1)'(cseb_pkg::SLOTS));
	assign state_on = (max_ctrl_q != '0) && basic_en_q;

	always_comb begin
		pick = '0;
		for (int i = cseb_pkg::SLOTS - 1; i >= 0; i--) begin
			if (disc_q[i]) begin
				pick = cseb_pkg::SLOT_W'(i);
			end
		end
		disc_rest       = disc_q;
		disc_rest[pick] = 1'b0;
	end

	assign scan_disc = |disc_q;
	assign scan_done = !scan_disc && !mask_q[idx_q];
	assign scan_have = !scan_disc && mask_q[idx_q] && active_q[idx_q];
	assign cap_full  = (cnt_q >= max_ctrl_q) || (next_id_q == '1);
	assign scan_err  = !scan_disc && mask_q[idx_q] && !active_q[idx_q] && cap_full;
	assign scan_new  = !scan_disc && mask_q[idx_q] && !active_q[idx_q] && !cap_full;
	assign caps      = cap_vld_rd_q ? rsp.cap_rd : '0;

	always_comb begin
		req   = '0;
		req.addr = idx_q;
		res_d = '0;
		load  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req.addr = slot_index;
				if (accept && bad_slot) begin
					load          = 1'b1;
					res_d.kind    = cseb_pkg::EV_BAD_SLOT;
					res_d.last    = 1'b1;
				end else if (accept && op == cseb_pkg::OP_ARRIVAL && !active_q[slot_index]) begin
					req.cap_we    = 1'b1;
					req.cap_wdata = {rumble_capable, cseb_pkg::remap_buttons(supported_buttons)};
				end
			end
			ST_SCAN: begin
				if (scan_disc) begin
					req.addr  = pick;
					req.id_re = 1'b1;
				end else if (scan_have) begin
					req.id_re  = 1'b1;
					req.cap_re = 1'b1;
				end else if (scan_new) begin
					req.id_we    = 1'b1;
					req.id_wdata = next_id_q;
					req.cap_re   = 1'b1;
				end
			end
			ST_DISC: begin
				load       = out_free;
				res_d.kind = cseb_pkg::EV_DISC;
				res_d.id   = rsp.id_rd;
				res_d.last = disc_last_q;
			end
			ST_CONN: begin
				load         = out_free;
				res_d.kind   = cseb_pkg::EV_CONN;
				res_d.id     = cur_id_q;
				res_d.btn    = caps[cseb_pkg::BTN_W-1:0];
				res_d.rumble = caps[cseb_pkg::BTN_W] && rumble_en_q;
			end
			ST_STATE: begin
				load       = out_free;
				res_d.kind = cseb_pkg::EV_STATE;
				res_d.id   = conn_q ? cur_id_q : rsp.id_rd;
				res_d.btn  = prs_q & caps[cseb_pkg::BTN_W-1:0];
				res_d.lx   = lx_q;
				res_d.ly   = ly_q;
				res_d.rx   = rx_q;
				res_d.ry   = ry_q;
				res_d.lt   = lt_q;
				res_d.rt   = rt_q;
				res_d.last = 1'b1;
			end
			ST_ERR: begin
				load       = out_free;
				res_d.kind = cseb_pkg::EV_CAPACITY;
				res_d.last = 1'b1;
			end
			default: begin
				load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_ctrl_q  <= '0;
			basic_en_q  <= 1'b0;
			rumble_en_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cseb_pkg::REG_MAX_CTRL:  max_ctrl_q  <= cfg_data;
				cseb_pkg::REG_BASIC_EN:  basic_en_q  <= cfg_data[0];
				cseb_pkg::REG_RUMBLE_EN: rumble_en_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			active_q     <= '0;
			cap_vld_q    <= '0;
			disc_q       <= '0;
			cnt_q        <= '0;
			next_id_q    <= cseb_pkg::ID_W'(1);
			cur_id_q     <= '0;
			conn_q       <= 1'b0;
			disc_last_q  <= 1'b0;
			cap_vld_rd_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept && !bad_slot) begin
						if (op == cseb_pkg::OP_ARRIVAL) begin
							if (!active_q[slot_index]) begin
								cap_vld_q[slot_index] <= 1'b1;
							end
						end else if (state_on) begin
							disc_q  <= active_q & ~present_mask[cseb_pkg::SLOTS-1:0];
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (scan_disc) begin
						active_q[pick]  <= 1'b0;
						cap_vld_q[pick] <= 1'b0;
						cnt_q           <= cnt_q - cseb_pkg::CNT_W'(1);
						disc_q          <= disc_rest;
						disc_last_q     <= (disc_rest == '0) && !mask_q[idx_q];
						state_q         <= ST_DISC;
					end else if (scan_done) begin
						state_q <= ST_IDLE;
					end else if (scan_have) begin
						conn_q       <= 1'b0;
						cap_vld_rd_q <= cap_vld_q[idx_q];
						state_q      <= ST_STATE;
					end else if (scan_err) begin
						state_q <= ST_ERR;
					end else begin
						active_q[idx_q] <= 1'b1;
						cnt_q           <= cnt_q + cseb_pkg::CNT_W'(1);
						next_id_q       <= next_id_q + cseb_pkg::ID_W'(1);
						cur_id_q        <= next_id_q;
						conn_q          <= 1'b1;
						cap_vld_rd_q    <= cap_vld_q[idx_q];
						state_q         <= ST_CONN;
					end
				end
				ST_DISC: begin
					if (out_free) begin
						state_q <= ST_SCAN;
					end
				end
				ST_CONN: begin
					if (out_free) begin
						state_q <= ST_STATE;
					end
				end
				ST_STATE, ST_ERR: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			idx_q  <= slot_index;
			mask_q <= present_mask[cseb_pkg::SLOTS-1:0];
			prs_q  <= cseb_pkg::remap_buttons(pressed_buttons);
			lx_q   <= left_stick_x;
			ly_q   <= cseb_pkg::neg_sat16(left_stick_y);
			rx_q   <= right_stick_x;
			ry_q   <= cseb_pkg::neg_sat16(right_stick_y);
			lt_q   <= {left_trigger_in, left_trigger_in};
			rt_q   <= {right_trigger_in, right_trigger_in};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= res_d;
		end
	end

	assign out_valid         = out_valid_q;
	assign event_kind        = out_q.kind;
	assign assigned_id       = out_q.id;
	assign button_bits       = out_q.btn;
	assign rumble_supported  = out_q.rumble;
	assign left_x_out        = out_q.lx;
	assign left_y_out        = out_q.ly;
	assign right_x_out       = out_q.rx;
	assign right_y_out       = out_q.ry;
	assign left_trigger_out  = out_q.lt;
	assign right_trigger_out = out_q.rt;
	assign last              = out_q.last;

endmodule

// ----- design/cseb_slot_table.sv -----
module cseb_slot_table (
	input  logic               clk,
	input  cseb_pkg::tbl_req_t req,
	output cseb_pkg::tbl_rsp_t rsp
);

	logic [cseb_pkg::ID_W-1:0]  id_mem  [cseb_pkg::SLOTS];
	logic [cseb_pkg::BTN_W:0]   cap_mem [cseb_pkg::SLOTS];
	logic [cseb_pkg::ID_W-1:0]  id_rd_q;
	logic [cseb_pkg::BTN_W:0]   cap_rd_q;

	always_ff @(posedge clk) begin
		if (req.id_we) begin
			id_mem[req.addr] <= req.id_wdata;
		end
		if (req.id_re) begin
			id_rd_q <= id_mem[req.addr];
		end
	end

	always_ff @(posedge clk) begin
		if (req.cap_we) begin
			cap_mem[req.addr] <= req.cap_wdata;
		end
		if (req.cap_re) begin
			cap_rd_q <= cap_mem[req.addr];
		end
	end

	assign rsp.id_rd  = id_rd_q;
	assign rsp.cap_rd = cap_rd_q;

endmodule

// ----- design/cseb_checker.sv -----
`include "controller_slot_event_bridge_top_macros.svh"

module cseb_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_stall,
	input logic [2:0]         event_kind,
	input logic [31:0]        assigned_id,
	input logic               last
);

	// held transaction keeps its payload
	`CSEB_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(event_kind) && $stable(assigned_id) && $stable(last), "stalled result changed")

	// error results close the transaction and carry no id
	`CSEB_ASSERT_IMP(a_err_last, out_valid && (event_kind == cseb_pkg::EV_BAD_SLOT || event_kind == cseb_pkg::EV_CAPACITY), last && assigned_id == '0, "error result not final or has id")

	// a connect is not final and carries an id; its state event follows
	`CSEB_ASSERT_IMP(a_conn_not_last, out_valid && event_kind == cseb_pkg::EV_CONN, !last && assigned_id != '0, "connect result marked final or has no id")

	// state event ends the transaction
	`CSEB_ASSERT_IMP(a_state_last, out_valid && event_kind == cseb_pkg::EV_STATE, last && assigned_id != '0, "state result not final or has no id")

endmodule

bind controller_slot_event_bridge_top cseb_checker u_cseb_checker (.*);
